// ===== hdl/periodic_lattice_energy_tracker_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the periodic lattice energy tracker.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_LATTICE_ENERGY_TRACKER_DEFINES_SVH
`define PERIODIC_LATTICE_ENERGY_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PLET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PLET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLET_ASSERT_SAME(lbl, ante, cons, msg)
`define PLET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/plet_pkg.sv =====
// ---------------------------------------------------------------------------
// plet_pkg
// Shared types and codes of the periodic lattice energy tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package plet_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_UPD
  } state_e;

  // Which site of the five-point stencil is addressed.
  typedef enum logic [2:0] {
    NBR_CENTER,
    NBR_RIGHT,
    NBR_LEFT,
    NBR_UP,
    NBR_DOWN
  } nbr_e;

  // Operation modes of an input transaction.
  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // Read sequencer counts: the center spin arrives at count one, the last
  // neighbor at count five.
  localparam logic [2:0] RD_OLD  = 3'd1;
  localparam logic [2:0] RD_LAST = 3'd5;

  localparam int STEP_W = 32;

endpackage

`default_nettype wire

// ===== hdl/plet_site_addr.sv =====
// ---------------------------------------------------------------------------
// plet_site_addr
// Forms the spin memory address of a site or one of its four neighbors,
// wrapping at the lattice edges.
// ---------------------------------------------------------------------------
`default_nettype none

module plet_site_addr #(
  parameter int MAX_SIDE = 64,
  parameter int COORD_W  = 6,
  parameter int CFG_W    = 7,
  parameter int ADDR_W   = 12
) (
  input  wire logic [COORD_W-1:0] x_i,
  input  wire logic [COORD_W-1:0] y_i,
  input  wire logic [CFG_W-1:0]   width_i,
  input  wire logic [CFG_W-1:0]   height_i,
  input  wire plet_pkg::nbr_e     sel_i,
  output logic      [ADDR_W-1:0]  addr_o
);

  logic [CFG_W-1:0]   xp1, yp1, wm1, hm1;
  logic [COORD_W-1:0] xr, xl, yu, yd;
  logic [COORD_W-1:0] ax, ay;

  // Wrapped neighbor coordinates.
  assign xp1 = CFG_W'(x_i) + CFG_W'(1);
  assign yp1 = CFG_W'(y_i) + CFG_W'(1);
  assign wm1 = width_i - CFG_W'(1);
  assign hm1 = height_i - CFG_W'(1);
  assign xr  = (xp1 == width_i)  ? '0 : xp1[COORD_W-1:0];
  assign yu  = (yp1 == height_i) ? '0 : yp1[COORD_W-1:0];
  assign xl  = (x_i == '0) ? wm1[COORD_W-1:0] : x_i - COORD_W'(1);
  assign yd  = (y_i == '0) ? hm1[COORD_W-1:0] : y_i - COORD_W'(1);

  // Stencil point selection.
  always_comb begin
    ax = x_i;
    ay = y_i;
    case (sel_i)
      plet_pkg::NBR_RIGHT: ax = xr;
      plet_pkg::NBR_LEFT:  ax = xl;
      plet_pkg::NBR_UP:    ay = yu;
      plet_pkg::NBR_DOWN:  ay = yd;
      default: begin
        ax = x_i;
        ay = y_i;
      end
    endcase
  end

  // Row-major address with a fixed row pitch of MAX_SIDE.
  assign addr_o = ADDR_W'(ay) * ADDR_W'(MAX_SIDE) + ADDR_W'(ax);

endmodule

`default_nettype wire

// ===== hdl/periodic_lattice_energy_tracker.sv =====
// ---------------------------------------------------------------------------
// periodic_lattice_energy_tracker
// Two-dimensional spin lattice with periodic wrap that tracks pair energy,
// magnetization and a committed step count by neighbor delta updates.
// ---------------------------------------------------------------------------
// An input transaction is taken when start_i is high and busy_o is low. A
// site inside the lattice keeps the block busy while the read state streams
// the center spin and its four neighbors through the single read port of the
// spin memory, the multiply state forms the energy delta in the multiplier,
// and the update state updates the totals and writes the new spin. A site
// outside the lattice goes straight to the update state. The result appears
// for one cycle with done_o in the cycle after the update state, and the
// receiver cannot stall it; a new transaction may be taken in that same cycle.
// After reset, and after every write to a side register, the block sweeps
// every spin memory entry to zero, one entry per cycle, with busy_o high.
// Configuration writes are always taken and are meant for idle periods.
// ---------------------------------------------------------------------------
`default_nettype none

`include "periodic_lattice_energy_tracker_defines.svh"

module periodic_lattice_energy_tracker #(
  parameter  int MAX_SIDE  = 64,
  parameter  int SPIN_BITS = 4,
  localparam int COORD_W   = $clog2(MAX_SIDE),
  localparam int CFG_W     = $clog2(MAX_SIDE + 1),
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE,
  localparam int ENERGY_W  = $clog2(2 * DEPTH) + 2 * (SPIN_BITS - 1) + 2,
  localparam int MAG_W     = $clog2(DEPTH) + SPIN_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input transactions
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic        [1:0]           mode_i,
  input  wire logic        [COORD_W-1:0]   x_coord_i,
  input  wire logic        [COORD_W-1:0]   y_coord_i,
  input  wire logic signed [SPIN_BITS-1:0] new_spin_i,
  // Configuration writes
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [1:0]           cfg_index_i,
  input  wire logic        [CFG_W-1:0]     cfg_data_i,
  // Results
  output logic                             done_o,
  output logic signed [SPIN_BITS-1:0]      old_spin_o,
  output logic signed [ENERGY_W-1:0]       total_energy_o,
  output logic signed [MAG_W-1:0]          total_magnetization_o,
  output logic        [plet_pkg::STEP_W-1:0] step_total_o
);

  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int D_W        = SPIN_BITS + 1;
  localparam int NSUM_W     = SPIN_BITS + 2;
  localparam int PROD_W     = D_W + NSUM_W;
  localparam int RESET_SIDE = 64;
  localparam int SIDE_RST   = (MAX_SIDE < RESET_SIDE) ? MAX_SIDE : RESET_SIDE;

  // Clamp a side register to the supported range.
  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] r;
    r = raw;
    if (raw < CFG_W'(2)) begin
      r = CFG_W'(2);
    end else if (raw > CFG_W'(MAX_SIDE)) begin
      r = CFG_W'(MAX_SIDE);
    end
    return r;
  endfunction

  plet_pkg::state_e state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              done_q, done_d;
  logic              cap_en, mul_en, upd_en, clr_we;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] width_eff, height_eff;

  logic signed [ENERGY_W-1:0]       energy_q;
  logic signed [MAG_W-1:0]          magnet_q;
  logic [plet_pkg::STEP_W-1:0]      step_q;

  logic [1:0]                  mode_q;
  logic [COORD_W-1:0]          x_q, y_q;
  logic signed [SPIN_BITS-1:0] nv_q;
  logic                        valid_q;
  logic signed [SPIN_BITS-1:0] old_q;
  logic signed [D_W-1:0]       d_q;
  logic signed [NSUM_W-1:0]    nsum_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [SPIN_BITS-1:0] old_spin_q;

  logic [SPIN_BITS-1:0]        spin_mem [DEPTH];
  logic signed [SPIN_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [SPIN_BITS-1:0]        mem_wdata;

  logic accept, in_range, cfg_we, wr_item;

  // Handshake and decode.
  assign busy_o      = (state_q != plet_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i &&
                       (cfg_index_i == plet_pkg::REG_WIDTH ||
                        cfg_index_i == plet_pkg::REG_HEIGHT);
  assign width_eff   = clamp_side(width_q);
  assign height_eff  = clamp_side(height_q);
  assign in_range    = (CFG_W'(x_coord_i) < width_eff) && (CFG_W'(y_coord_i) < height_eff);
  assign wr_item     = valid_q && (mode_q == plet_pkg::MODE_SET ||
                                   mode_q == plet_pkg::MODE_STEP);

  // Stencil address generation.
  plet_site_addr #(
    .MAX_SIDE (MAX_SIDE),
    .COORD_W  (COORD_W),
    .CFG_W    (CFG_W),
    .ADDR_W   (ADDR_W)
  ) u_site_addr (
    .x_i      (x_q),
    .y_i      (y_q),
    .width_i  (width_eff),
    .height_i (height_eff),
    .sel_i    (plet_pkg::nbr_e'(cnt_q)),
    .addr_o   (rd_addr)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= plet_pkg::ST_CLEAR;
      cnt_q     <= '0;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  // Next state and sequencer controls.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    clr_cnt_d = clr_cnt_q;
    done_d    = 1'b0;
    cap_en    = 1'b0;
    mul_en    = 1'b0;
    upd_en    = 1'b0;
    clr_we    = 1'b0;
    case (state_q)
      plet_pkg::ST_CLEAR: begin
        clr_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = plet_pkg::ST_IDLE;
        end
      end
      plet_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = in_range ? plet_pkg::ST_READ : plet_pkg::ST_UPD;
        end
      end
      plet_pkg::ST_READ: begin
        cnt_d  = cnt_q + 3'd1;
        cap_en = (cnt_q != '0);
        if (cnt_q == plet_pkg::RD_LAST) begin
          state_d = plet_pkg::ST_MUL;
        end
      end
      plet_pkg::ST_MUL: begin
        mul_en  = 1'b1;
        state_d = plet_pkg::ST_UPD;
      end
      plet_pkg::ST_UPD: begin
        upd_en  = 1'b1;
        done_d  = 1'b1;
        state_d = plet_pkg::ST_IDLE;
      end
      default: begin
        state_d = plet_pkg::ST_CLEAR;
      end
    endcase
    // A side register write restarts the clearing sweep.
    if (cfg_we) begin
      state_d   = plet_pkg::ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  // Spin memory: one write port, one registered read port.
  assign mem_we    = clr_we || (upd_en && wr_item);
  assign mem_waddr = clr_we ? clr_cnt_q : rd_addr;
  assign mem_wdata = clr_we ? '0 : nv_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      spin_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= spin_mem[rd_addr];
  end

  // Configuration registers and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(SIDE_RST);
      height_q <= CFG_W'(SIDE_RST);
      energy_q <= '0;
      magnet_q <= '0;
      step_q   <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == plet_pkg::REG_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
      energy_q <= '0;
      magnet_q <= '0;
      step_q   <= '0;
    end else if (upd_en && wr_item) begin
      energy_q <= energy_q - ENERGY_W'(prod_q);
      magnet_q <= magnet_q + MAG_W'(d_q);
      if (mode_q == plet_pkg::MODE_STEP) begin
        step_q <= step_q + plet_pkg::STEP_W'(1);
      end
    end
  end

  // Item datapath: capture, neighbor sum, delta product and result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      x_q     <= x_coord_i;
      y_q     <= y_coord_i;
      nv_q    <= new_spin_i;
      valid_q <= in_range;
      nsum_q  <= '0;
    end
    if (cap_en) begin
      if (cnt_q == plet_pkg::RD_OLD) begin
        old_q <= rdata_q;
        d_q   <= D_W'(nv_q) - D_W'(rdata_q);
      end else begin
        nsum_q <= nsum_q + NSUM_W'(rdata_q);
      end
    end
    if (mul_en) begin
      prod_q <= d_q * nsum_q;
    end
    if (upd_en) begin
      old_spin_q <= valid_q ? old_q : '0;
    end
  end

  // Result ports.
  assign done_o                = done_q;
  assign old_spin_o            = old_spin_q;
  assign total_energy_o        = energy_q;
  assign total_magnetization_o = magnet_q;
  assign step_total_o          = step_q;

  // Assertions.
  `PLET_ASSERT_SAME(a_done_after_update, done_o, $past(state_q == plet_pkg::ST_UPD), "result strobe without an update cycle")
  `PLET_ASSERT_NEXT(a_accept_goes_busy, start_i && !busy_o, busy_o, "accepted transaction left the block idle")
  `PLET_ASSERT_NEXT(a_read_holds_totals, state_q == plet_pkg::ST_READ && !cfg_we, $stable(step_q) && $stable(energy_q) && $stable(magnet_q), "totals changed during the neighbor reads")
  `PLET_ASSERT_NEXT(a_cfg_clears, cfg_we, state_q == plet_pkg::ST_CLEAR && step_q == '0 && magnet_q == '0, "register write did not start a clearing sweep")

endmodule

`default_nettype wire

// ===== test/tb_periodic_lattice_energy_tracker.sv =====
// ---------------------------------------------------------------------------
// tb_periodic_lattice_energy_tracker
// Self-checking bench for the periodic lattice energy tracker. A directed
// table covers wraparound at both edges, the smallest lattice, clamped side
// registers, sites outside the lattice and the alias of the read mode. A
// random part follows over several lattice shapes. Typed rows are held to
// their table values, the rest to a behavioral predictor of the lattice.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_lattice_energy_tracker;

  localparam int MAX_SIDE        = 64;
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int IDLE_PCT        = 35;

  // Mode 3 behaves as a read; index 2 names no register.
  localparam logic [1:0] MODE_READ_ALIAS = 2'd3;
  localparam logic [1:0] REG_SPARE       = 2'd2;

  typedef struct packed {
    logic signed [3:0]  old_spin;
    logic signed [20:0] energy;
    logic signed [15:0] magnet;
    logic [31:0]        steps;
  } lattice_report_t;

  // One row of the directed table: a site transaction or a register write.
  typedef struct {
    bit              is_cfg;
    logic [1:0]      op;
    logic [6:0]      a;
    logic [5:0]      y;
    logic [3:0]      spin;
    bit              typed;
    lattice_report_t want;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [1:0]                    mode_i;
  logic [5:0]                    x_coord_i;
  logic [5:0]                    y_coord_i;
  logic signed [3:0]             new_spin_i;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_index_i;
  logic [6:0]                    cfg_data_i;
  logic                          done_o;
  logic signed [3:0]             old_spin_o;
  logic signed [20:0]            total_energy_o;
  logic signed [15:0]            total_magnetization_o;
  logic [plet_pkg::STEP_W-1:0]   step_total_o;

  // Shadow copy of the lattice and its totals.
  logic signed [3:0] spin_shadow [MAX_SIDE*MAX_SIDE];
  int                energy_shadow;
  int                magnet_shadow;
  logic [31:0]       step_shadow;
  logic [6:0]        width_reg_shadow;
  logic [6:0]        height_reg_shadow;

  lattice_report_t   expected_reports[$];
  stim_row_t         directed_rows[$];
  int                mismatch_count = 0;
  int                stall_cycles = 0;
  int                random_sent = 0;

  periodic_lattice_energy_tracker u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .mode_i                (mode_i),
    .x_coord_i             (x_coord_i),
    .y_coord_i             (y_coord_i),
    .new_spin_i            (new_spin_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .done_o                (done_o),
    .old_spin_o            (old_spin_o),
    .total_energy_o        (total_energy_o),
    .total_magnetization_o (total_magnetization_o),
    .step_total_o          (step_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Side registers are clamped to the supported range of the lattice.
  function automatic int side_of(logic [6:0] reg_value);
    if (reg_value < 2) return 2;
    if (reg_value > MAX_SIDE) return MAX_SIDE;
    return int'(reg_value);
  endfunction

  function automatic void clear_lattice_shadow();
    foreach (spin_shadow[i]) spin_shadow[i] = 4'sd0;
    energy_shadow = 0;
    magnet_shadow = 0;
    step_shadow   = '0;
  endfunction

  // Applies one site transaction to the shadow lattice and returns the report.
  function automatic lattice_report_t update_lattice(logic [1:0] mode, logic [5:0] x,
                                                     logic [5:0] y, logic signed [3:0] spin);
    lattice_report_t   rep;
    int                w, h, xi, yi, xr, xl, yu, yd, nsum, delta;
    logic signed [3:0] prior;
    w     = side_of(width_reg_shadow);
    h     = side_of(height_reg_shadow);
    xi    = int'(x);
    yi    = int'(y);
    prior = 4'sd0;
    if (xi < w && yi < h) begin
      prior = spin_shadow[yi*MAX_SIDE + xi];
      if (mode == plet_pkg::MODE_SET || mode == plet_pkg::MODE_STEP) begin
        xr = (xi + 1 == w) ? 0 : xi + 1;
        xl = (xi == 0) ? w - 1 : xi - 1;
        yu = (yi + 1 == h) ? 0 : yi + 1;
        yd = (yi == 0) ? h - 1 : yi - 1;
        // On a side of two both neighbors along that axis are the same site.
        nsum = int'(spin_shadow[yi*MAX_SIDE + xr]) + int'(spin_shadow[yi*MAX_SIDE + xl])
             + int'(spin_shadow[yu*MAX_SIDE + xi]) + int'(spin_shadow[yd*MAX_SIDE + xi]);
        delta = int'(spin) - int'(prior);
        energy_shadow -= delta * nsum;
        magnet_shadow += delta;
        spin_shadow[yi*MAX_SIDE + xi] = spin;
        if (mode == plet_pkg::MODE_STEP) step_shadow += 32'd1;
      end
    end
    rep.old_spin = prior;
    rep.energy   = energy_shadow[20:0];
    rep.magnet   = magnet_shadow[15:0];
    rep.steps    = step_shadow;
    return rep;
  endfunction

  function automatic stim_row_t site_row(logic [1:0] mode, int x, int y, int spin);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.op     = mode;
    r.a      = 7'(x);
    r.y      = 6'(y);
    r.spin   = 4'(spin);
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] mode, int x, int y, int spin,
                                         int old, int energy, int magnet, int steps);
    stim_row_t r;
    r = site_row(mode, x, y, spin);
    r.typed         = 1'b1;
    r.want.old_spin = old[3:0];
    r.want.energy   = energy[20:0];
    r.want.magnet   = magnet[15:0];
    r.want.steps    = steps;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [1:0] idx, int value);
    stim_row_t r;
    r = site_row(idx, 0, 0, 0);
    r.is_cfg = 1'b1;
    r.a      = 7'(value);
    return r;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void queue_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Holds start low for a random number of cycles.
  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offers one site transaction and queues its expected report once taken.
  // Start stays high on return so back-to-back transactions need no gap.
  task automatic send_site(logic [1:0] mode, logic [5:0] x, logic [5:0] y,
                           logic [3:0] spin, bit typed, lattice_report_t want);
    bit              taken;
    lattice_report_t predicted;
    start_i    <= 1'b1;
    mode_i     <= mode;
    x_coord_i  <= x;
    y_coord_i  <= y;
    new_spin_i <= spin;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end
    predicted = update_lattice(mode, x, y, spin);
    expected_reports.insert(expected_reports.size(), typed ? want : predicted);
  endtask

  // Writes a register once the block has drained and finished any clear sweep.
  task automatic write_register(logic [1:0] idx, logic [6:0] value);
    bit taken;
    start_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (cfg_ready_o === 1'b1);
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    // Any write to a side register clears the lattice and all totals.
    if (idx == plet_pkg::REG_WIDTH) begin
      width_reg_shadow = value;
      clear_lattice_shadow();
    end else if (idx == plet_pkg::REG_HEIGHT) begin
      height_reg_shadow = value;
      clear_lattice_shadow();
    end
  endtask

  // One random phase: most sites fall in a small window so that neighbors
  // interact; a few fall outside the lattice.
  task automatic run_random_phase(int count);
    int         w, h, win_x, win_y, r, m;
    logic [5:0] x, y;
    logic [1:0] mode;
    w     = side_of(width_reg_shadow);
    h     = side_of(height_reg_shadow);
    win_x = $urandom_range(w - 1);
    win_y = $urandom_range(h - 1);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8 && (w < MAX_SIDE || h < MAX_SIDE)) begin
        if (w < MAX_SIDE && (h == MAX_SIDE || $urandom_range(1) == 1)) begin
          x = 6'($urandom_range(63, w));
          y = 6'($urandom_range(63));
        end else begin
          x = 6'($urandom_range(63));
          y = 6'($urandom_range(63, h));
        end
      end else if (r < 75) begin
        x = 6'((win_x + $urandom_range(3)) % w);
        y = 6'((win_y + $urandom_range(3)) % h);
      end else begin
        x = 6'($urandom_range(w - 1));
        y = 6'($urandom_range(h - 1));
      end
      m = $urandom_range(9);
      if (m == 0) mode = plet_pkg::MODE_READ;
      else if (m == 1) mode = MODE_READ_ALIAS;
      else if (m < 6) mode = plet_pkg::MODE_SET;
      else mode = plet_pkg::MODE_STEP;
      // A long stretch of the run goes without any gaps.
      idle_gap((random_sent >= 320 && random_sent < 440) ? 0 : IDLE_PCT);
      send_site(mode, x, y, 4'($urandom_range(15)), 1'b0, '0);
      random_sent++;
    end
  endtask

  // Result checker: each strobed result is matched with the oldest expectation.
  always @(negedge clk_i) begin : check_results
    lattice_report_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: old_spin %0d energy %0d magnet %0d steps %0d",
                 $time, old_spin_o, total_energy_o, total_magnetization_o, step_total_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (old_spin_o !== want.old_spin) begin
          $display("%0t: old_spin expected %0d actual %0d", $time, want.old_spin, old_spin_o);
          mismatch_count++;
        end
        if (total_energy_o !== want.energy) begin
          $display("%0t: total_energy expected %0d actual %0d",
                   $time, want.energy, total_energy_o);
          mismatch_count++;
        end
        if (total_magnetization_o !== want.magnet) begin
          $display("%0t: total_magnetization expected %0d actual %0d",
                   $time, want.magnet, total_magnetization_o);
          mismatch_count++;
        end
        if (step_total_o !== want.steps) begin
          $display("%0t: step_total expected %0d actual %0d",
                   $time, want.steps, step_total_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind moves for too long.
  always @(negedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [6:0] phase_w [10];
    logic [6:0] phase_h [10];
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    mode_i      <= plet_pkg::MODE_READ;
    x_coord_i   <= '0;
    y_coord_i   <= '0;
    new_spin_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= plet_pkg::REG_WIDTH;
    cfg_data_i  <= '0;
    width_reg_shadow  = 7'd64;
    height_reg_shadow = 7'd64;
    clear_lattice_shadow();

    // Directed table: full lattice first, with wrap on both axes.
    queue_row(typed_row(plet_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_row(typed_row(MODE_READ_ALIAS, 63, 63, 7, 0, 0, 0, 0));
    queue_row(typed_row(plet_pkg::MODE_SET, 0, 0, -8, 0, 0, -8, 0));
    queue_row(site_row(plet_pkg::MODE_STEP, 63, 0, 7));
    queue_row(site_row(plet_pkg::MODE_STEP, 0, 63, 7));
    queue_row(site_row(plet_pkg::MODE_STEP, 0, 0, -8));
    queue_row(site_row(plet_pkg::MODE_SET, 1, 0, 7));
    queue_row(site_row(plet_pkg::MODE_READ, 0, 0, 3));
    queue_row(site_row(plet_pkg::MODE_STEP, 0, 0, 7));
    // Side registers below range clamp to the two by two lattice.
    queue_row(reg_row(plet_pkg::REG_WIDTH, 0));
    queue_row(reg_row(plet_pkg::REG_HEIGHT, 1));
    queue_row(typed_row(plet_pkg::MODE_READ, 2, 0, 0, 0, 0, 0, 0));
    queue_row(typed_row(plet_pkg::MODE_STEP, 0, 63, 7, 0, 0, 0, 0));
    queue_row(typed_row(plet_pkg::MODE_SET, 0, 0, -8, 0, 0, -8, 0));
    queue_row(site_row(plet_pkg::MODE_STEP, 1, 1, -8));
    queue_row(site_row(plet_pkg::MODE_STEP, 1, 0, 7));
    queue_row(site_row(plet_pkg::MODE_STEP, 0, 1, 7));
    queue_row(site_row(plet_pkg::MODE_READ, 1, 1, 0));
    // Side registers above range clamp to the full lattice.
    queue_row(reg_row(plet_pkg::REG_WIDTH, 127));
    queue_row(reg_row(plet_pkg::REG_HEIGHT, 65));
    queue_row(reg_row(REG_SPARE, 5));
    queue_row(typed_row(plet_pkg::MODE_READ, 63, 63, 0, 0, 0, 0, 0));
    queue_row(site_row(plet_pkg::MODE_SET, 63, 63, 7));
    queue_row(site_row(plet_pkg::MODE_STEP, 62, 63, -8));
    queue_row(site_row(plet_pkg::MODE_STEP, 63, 62, -8));

    phase_w = '{7'd2, 7'd64, 7'd2, 7'd64, 7'd0, 7'd3, 7'd127, 7'd1, 7'd0, 7'd0};
    phase_h = '{7'd2, 7'd64, 7'd64, 7'd2, 7'd127, 7'd5, 7'd1, 7'd65, 7'd0, 7'd0};
    for (int p = 8; p < 10; p++) begin
      phase_w[p] = 7'($urandom_range(127));
      phase_h[p] = 7'($urandom_range(127));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_register(directed_rows[i].op, directed_rows[i].a);
      end else begin
        idle_gap(IDLE_PCT);
        send_site(directed_rows[i].op, directed_rows[i].a[5:0], directed_rows[i].y,
                  directed_rows[i].spin, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases over several lattice shapes, extremes included.
    for (int p = 0; p < 10; p++) begin
      write_register(plet_pkg::REG_WIDTH, phase_w[p]);
      write_register(plet_pkg::REG_HEIGHT, phase_h[p]);
      run_random_phase(ITEMS_PER_PHASE);
    end

    // Drain the last results and allow for any stray strobe.
    start_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/plet_pkg.sv
hdl/plet_site_addr.sv
hdl/periodic_lattice_energy_tracker.sv
test/tb_periodic_lattice_energy_tracker.sv
